// ----- sv/slt_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// slt_pkg
// shared types and constants of the slot table with first-free reuse
// ----------------------------------------------------------------------------
package slt_pkg;

    localparam int CAPACITY_DEF = 64;

    localparam int ID_W     = 32;
    localparam int PROC_W   = 31;
    localparam int GENOME_W = 64;
    localparam int STATUS_W = 3;
    localparam int SLOT_W   = 6;
    localparam int USED_W   = 7;

    // input tdata: rec_id, proc_num, genome, padded to whole bytes
    localparam int S_DATA_W = ((ID_W + PROC_W + GENOME_W + 7) / 8) * 8;
    // output tdata: slot, used_count, padded to whole bytes
    localparam int M_DATA_W = ((SLOT_W + USED_W + 7) / 8) * 8;

    localparam logic ACT_INSERT = 1'b0;
    localparam logic ACT_REMOVE = 1'b1;

    typedef enum logic [STATUS_W-1:0] {
        ST_REUSED   = 3'd0,
        ST_APPENDED = 3'd1,
        ST_REMOVED  = 3'd2,
        ST_MISSING  = 3'd3,
        ST_FULL     = 3'd4
    } status_t;

    // one stored record
    typedef struct packed {
        logic                valid;
        logic [PROC_W-1:0]   proc_num;
        logic [ID_W-1:0]     rec_id;
        logic [GENOME_W-1:0] genome;
    } rec_t;

    localparam int REC_W = $bits(rec_t);

endpackage
`default_nettype wire

// ----- sv/slt_ram.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// slt_ram
// simple dual-port ram, one write and one registered read port
// ----------------------------------------------------------------------------
module slt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             aclk,
    input  wire logic             wr_en,
    input  wire logic [AW-1:0]    wr_addr,
    input  wire logic [WIDTH-1:0] wr_data,
    input  wire logic             rd_en,
    input  wire logic [AW-1:0]    rd_addr,
    output logic      [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule
`default_nettype wire

// ----- sv/slot_table_reuse_and_invalidate_unit.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// slot_table_reuse_and_invalidate_unit
// process record table with first-free slot reuse and remove by process number
// ----------------------------------------------------------------------------
// input channel s_*: one transfer per command. s_tuser is the action (insert
// or remove), s_tdata carries rec_id, proc_num and genome.
// output channel m_*: one transfer per command. m_tuser is the status code,
// m_tdata carries the slot touched (zero when none) and the used count.
// records live in one synchronous ram; a command scans slots upward from
// zero, one ram read per cycle while no result waits on a stalled receiver,
// up to the current used count. the first hit (a clear valid mark for
// insert, a matching process number for remove) is modified and written
// back in the cycle it is seen. the result is registered on a hit, or once
// every used slot is read with no hit; a command on an empty table reads
// no ram entry.
// one command is worked on at a time: the input is taken again in the cycle
// after the result is registered.
// reset: the used count goes to zero, so no ram entry is read before it is
// written and no clearing pass is needed.
// a stalled receiver holds the result register; the scan of the following
// command then freezes until the result is taken.
// ----------------------------------------------------------------------------
module slot_table_reuse_and_invalidate_unit
    import slt_pkg::*;
#(
    parameter int CAPACITY = CAPACITY_DEF
) (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    // input stream
    input  wire logic                s_tvalid,
    output logic                     s_tready,
    input  wire logic [S_DATA_W-1:0] s_tdata,   // rec_id[31:0], proc_num[62:32], genome[126:63]
    input  wire logic                s_tuser,   // action[0]
    // result stream
    output logic                     m_tvalid,
    input  wire logic                m_tready,
    output logic      [M_DATA_W-1:0] m_tdata,   // slot[5:0], used_count[12:6]
    output logic      [STATUS_W-1:0] m_tuser    // status[2:0]
);

    localparam int IW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CW = $clog2(CAPACITY + 1);
    localparam logic [CW-1:0] CAP_C = CW'(CAPACITY);

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_SCAN = 2'b10
    } state_t;

    state_t state_reg, state_next;

    // command held for the scan
    logic                act_reg;
    logic [ID_W-1:0]     id_reg;
    logic [PROC_W-1:0]   proc_reg;
    logic [GENOME_W-1:0] genome_reg;

    // scan control
    logic [CW-1:0] issue_reg, issue_next;   // next slot to read
    logic          pend_reg, pend_next;     // ram data of pidx_reg is valid
    logic [IW-1:0] pidx_reg, pidx_next;
    logic [CW-1:0] count_reg, count_next;   // slots in use

    // result register
    logic                m_tvalid_reg, m_tvalid_next;
    status_t             status_reg, status_next;
    logic [SLOT_W-1:0]   slot_reg, slot_next;
    logic [USED_W-1:0]   used_reg, used_next;

    // ram port signals
    logic             rd_en;
    logic [REC_W-1:0] rd_data;
    logic             wr_en;
    logic [IW-1:0]    wr_addr;
    rec_t             wr_rec;
    rec_t             rd_rec;

    logic s_fire;
    logic out_free;
    logic scan_go;
    logic match;
    logic more;
    logic resolve;
    logic can_append;

    assign rd_rec     = rec_t'(rd_data);
    assign s_fire     = s_tvalid && s_tready;
    assign out_free   = !m_tvalid_reg || m_tready;
    assign scan_go    = (state_reg == S_SCAN) && out_free;
    assign more       = issue_reg < count_reg;
    assign can_append = count_reg < CAP_C;

    // hit test on the entry just read
    always_comb begin
        if (act_reg == ACT_INSERT) begin
            match = pend_reg && !rd_rec.valid;
        end else begin
            match = pend_reg && (rd_rec.proc_num == proc_reg);
        end
    end

    // a hit, or every used slot read with no hit
    assign resolve = scan_go && (match || (!pend_reg && !more));
    // no read on a hit, so the hit entry stays on the read port for write-back
    assign rd_en   = scan_go && !match && more;

    always_comb begin
        wr_en   = 1'b0;
        wr_addr = pidx_reg;
        wr_rec  = rd_rec;
        if (resolve) begin
            if (act_reg == ACT_INSERT) begin
                wr_rec.valid    = 1'b1;
                wr_rec.proc_num = proc_reg;
                wr_rec.rec_id   = id_reg;
                wr_rec.genome   = genome_reg;
                if (match) begin
                    wr_en = 1'b1;
                end else if (can_append) begin
                    wr_en   = 1'b1;
                    wr_addr = count_reg[IW-1:0];
                end
            end else begin
                // remove clears the mark, the rest of the record is kept
                wr_rec.valid = 1'b0;
                wr_en        = match;
            end
        end
    end

    slt_ram #(
        .WIDTH (REC_W),
        .DEPTH (CAPACITY)
    ) u_ram (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_rec),
        .rd_en   (rd_en),
        .rd_addr (issue_reg[IW-1:0]),
        .rd_data (rd_data)
    );

    // sequencer
    always_comb begin
        state_next    = state_reg;
        issue_next    = issue_reg;
        pend_next     = pend_reg;
        pidx_next     = pidx_reg;
        count_next    = count_reg;
        m_tvalid_next = m_tvalid_reg;
        status_next   = status_reg;
        slot_next     = slot_reg;
        used_next     = used_reg;

        if (m_tvalid_reg && m_tready) begin
            m_tvalid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE: begin
                if (s_fire) begin
                    issue_next = '0;
                    pend_next  = 1'b0;
                    state_next = S_SCAN;
                end
            end
            S_SCAN: begin
                if (resolve) begin
                    m_tvalid_next = 1'b1;
                    pend_next     = 1'b0;
                    state_next    = S_IDLE;
                    slot_next     = '0;
                    used_next     = USED_W'(count_reg);
                    if (match) begin
                        slot_next   = SLOT_W'(pidx_reg);
                        status_next = (act_reg == ACT_INSERT) ? ST_REUSED : ST_REMOVED;
                    end else if (act_reg == ACT_REMOVE) begin
                        status_next = ST_MISSING;
                    end else if (can_append) begin
                        status_next = ST_APPENDED;
                        slot_next   = SLOT_W'(count_reg);
                        count_next  = count_reg + 1'b1;
                        used_next   = USED_W'(count_reg + 1'b1);
                    end else begin
                        status_next = ST_FULL;
                    end
                end else if (scan_go) begin
                    pend_next = rd_en;
                    if (rd_en) begin
                        pidx_next  = issue_reg[IW-1:0];
                        issue_next = issue_reg + 1'b1;
                    end
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_IDLE;
            issue_reg    <= '0;
            pend_reg     <= 1'b0;
            count_reg    <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            issue_reg    <= issue_next;
            pend_reg     <= pend_next;
            count_reg    <= count_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    // payload, no reset
    always_ff @(posedge aclk) begin
        pidx_reg   <= pidx_next;
        status_reg <= status_next;
        slot_reg   <= slot_next;
        used_reg   <= used_next;
        if (s_fire) begin
            act_reg    <= s_tuser;
            id_reg     <= s_tdata[ID_W-1:0];
            proc_reg   <= s_tdata[ID_W+PROC_W-1:ID_W];
            genome_reg <= s_tdata[ID_W+PROC_W+GENOME_W-1:ID_W+PROC_W];
        end
    end

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tuser  = status_reg;
    assign m_tdata  = M_DATA_W'({used_reg, slot_reg});

endmodule
`default_nettype wire

// ----- sv/slt_checker.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// slt_checker
// port-level checks on the slot table result stream
// ----------------------------------------------------------------------------
module slt_checker
    import slt_pkg::*;
#(
    parameter int CAPACITY = CAPACITY_DEF
) (
    input wire logic                aclk,
    input wire logic                aresetn,
    input wire logic                s_tvalid,
    input wire logic                s_tready,
    input wire logic [S_DATA_W-1:0] s_tdata,
    input wire logic                s_tuser,
    input wire logic                m_tvalid,
    input wire logic                m_tready,
    input wire logic [M_DATA_W-1:0] m_tdata,
    input wire logic [STATUS_W-1:0] m_tuser
);

    logic [SLOT_W-1:0] res_slot;
    logic [USED_W-1:0] res_used;

    assign res_slot = m_tdata[SLOT_W-1:0];
    assign res_used = m_tdata[SLOT_W+USED_W-1:SLOT_W];

    // a stalled result holds
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("result changed while stalled");

    // no slot is reported when nothing was touched
    a_none_slot: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tuser == ST_MISSING || m_tuser == ST_FULL) |-> res_slot == '0)
        else $error("slot reported on miss or full");

    // an append lands on the last used slot
    a_append: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser == ST_APPENDED
        |-> res_used != '0 && res_slot == SLOT_W'(res_used - 1'b1))
        else $error("append slot does not follow used count");

    // known status codes and count in range
    a_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tuser <= ST_FULL && int'(res_used) <= CAPACITY)
        else $error("status or used count out of range");

    // a full table only comes with the count at capacity
    a_full: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser == ST_FULL |-> res_used == USED_W'(CAPACITY))
        else $error("table full reported below capacity");

endmodule

bind slot_table_reuse_and_invalidate_unit slt_checker #(
    .CAPACITY (CAPACITY)
) u_slt_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);
`default_nettype wire
